// ----- rtl/roc_pkg.sv -----
// Package for the confusion-matrix threshold counter.
// Holds the score and store sizes, the request function codes and the sequencer states.
// Has no dependencies.
package roc_pkg;

   // Score format and store sizing.
   localparam int ScoreWidth = 32;
   localparam int StoreDepth = 1024;
   localparam int AddrWidth  = $clog2(StoreDepth);
   localparam int CountWidth = $clog2(StoreDepth + 1);

   // Extreme score values.
   localparam logic signed [ScoreWidth-1:0] MostPos = {1'b0, {(ScoreWidth-1){1'b1}}};
   localparam logic signed [ScoreWidth-1:0] MostNeg = {1'b1, {(ScoreWidth-1){1'b0}}};

   // Request function codes.
   localparam logic [1:0] FuncAddPos = 2'd0;
   localparam logic [1:0] FuncAddNeg = 2'd1;
   localparam logic [1:0] FuncQuery  = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

// ----- rtl/roc_confusion_counter_core.sv -----
// Confusion-matrix threshold counter: two score stores, running extremes and a query walker.
// Depends on roc_pkg for sizes, function codes and the state type.
//
//   channel   | ports                                        | handshake
//   ----------+----------------------------------------------+--------------------------------
//   request   | req_func, req_score, req_threshold           | taken when start & !busy
//   response  | rsp_true_pos .. rsp_dropped                  | one cycle, marked by rsp_strobe
//
// An add request leaves busy low, so adds can arrive every cycle.
// A query walks the positive store and then the negative store through one compare unit,
// one entry per cycle; it holds busy through ST_WALK, ST_DRAIN and ST_RESULT, and the
// response appears in ST_RESULT, the last of them. Function code 3 is taken and ignored.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
// The receiver cannot stall: rsp_strobe marks the response for one cycle only.
module roc_confusion_counter_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_func,
   input  logic signed [roc_pkg::ScoreWidth-1:0]   req_score,
   input  logic signed [roc_pkg::ScoreWidth-1:0]   req_threshold,
   output logic                                    rsp_strobe,
   output logic [roc_pkg::CountWidth-1:0]          rsp_true_pos,
   output logic [roc_pkg::CountWidth-1:0]          rsp_false_neg,
   output logic [roc_pkg::CountWidth-1:0]          rsp_true_neg,
   output logic [roc_pkg::CountWidth-1:0]          rsp_false_pos,
   output logic signed [roc_pkg::ScoreWidth-1:0]   rsp_score_max,
   output logic signed [roc_pkg::ScoreWidth-1:0]   rsp_score_min,
   output logic                                    rsp_dropped
);

   // Score stores.
   logic signed [roc_pkg::ScoreWidth-1:0] pos_mem [roc_pkg::StoreDepth];
   logic signed [roc_pkg::ScoreWidth-1:0] neg_mem [roc_pkg::StoreDepth];

   // Control and state registers.
   roc_pkg::state_type                    state_ff, state_in;
   logic [roc_pkg::CountWidth-1:0]        pos_count_ff, pos_count_in;
   logic [roc_pkg::CountWidth-1:0]        neg_count_ff, neg_count_in;
   logic signed [roc_pkg::ScoreWidth-1:0] run_max_ff, run_max_in;
   logic signed [roc_pkg::ScoreWidth-1:0] run_min_ff, run_min_in;
   logic                                  overflow_ff, overflow_in;
   logic [roc_pkg::CountWidth-1:0]        idx_ff, idx_in;
   logic                                  phase_neg_ff, phase_neg_in;
   logic                                  rd_vld_ff, rd_vld_in;
   logic                                  rd_neg_ff, rd_neg_in;

   // Query payload registers.
   logic signed [roc_pkg::ScoreWidth-1:0] thr_ff, thr_in;
   logic [roc_pkg::CountWidth-1:0]        tp_ff, tp_in;
   logic [roc_pkg::CountWidth-1:0]        fn_ff, fn_in;
   logic [roc_pkg::CountWidth-1:0]        tn_ff, tn_in;
   logic [roc_pkg::CountWidth-1:0]        fp_ff, fp_in;
   logic signed [roc_pkg::ScoreWidth-1:0] pos_rd_ff;
   logic signed [roc_pkg::ScoreWidth-1:0] neg_rd_ff;

   // Memory controls.
   logic                                  pos_we;
   logic                                  neg_we;
   logic                                  pos_re;
   logic                                  neg_re;
   logic signed [roc_pkg::ScoreWidth-1:0] wr_value;

   // Shared compare unit.
   logic signed [roc_pkg::ScoreWidth-1:0] cmp_data;
   logic                                  cmp_ge;

   logic                                  accept;

   assign accept   = start && (state_ff == roc_pkg::ST_IDLE);
   assign cmp_data = rd_neg_ff ? neg_rd_ff : pos_rd_ff;
   assign cmp_ge   = (cmp_data >= thr_ff);

   // State register and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= roc_pkg::ST_IDLE;
         pos_count_ff <= '0;
         neg_count_ff <= '0;
         run_max_ff   <= roc_pkg::MostNeg;
         run_min_ff   <= roc_pkg::MostPos;
         overflow_ff  <= 1'b0;
         idx_ff       <= '0;
         phase_neg_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_neg_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_count_ff <= pos_count_in;
         neg_count_ff <= neg_count_in;
         run_max_ff   <= run_max_in;
         run_min_ff   <= run_min_in;
         overflow_ff  <= overflow_in;
         idx_ff       <= idx_in;
         phase_neg_ff <= phase_neg_in;
         rd_vld_ff    <= rd_vld_in;
         rd_neg_ff    <= rd_neg_in;
      end
   end

   // Query payload registers need no reset.
   always_ff @(posedge clock) begin
      thr_ff <= thr_in;
      tp_ff  <= tp_in;
      fn_ff  <= fn_in;
      tn_ff  <= tn_in;
      fp_ff  <= fp_in;
   end

   // Positive store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_count_ff[roc_pkg::AddrWidth-1:0]] <= wr_value;
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem[idx_ff[roc_pkg::AddrWidth-1:0]];
      end
   end

   // Negative store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (neg_we) begin
         neg_mem[neg_count_ff[roc_pkg::AddrWidth-1:0]] <= wr_value;
      end
      if (neg_re) begin
         neg_rd_ff <= neg_mem[idx_ff[roc_pkg::AddrWidth-1:0]];
      end
   end

   // Next state, store updates and the query walk.
   always_comb begin
      state_in     = state_ff;
      pos_count_in = pos_count_ff;
      neg_count_in = neg_count_ff;
      run_max_in   = run_max_ff;
      run_min_in   = run_min_ff;
      overflow_in  = overflow_ff;
      idx_in       = idx_ff;
      phase_neg_in = phase_neg_ff;
      rd_vld_in    = 1'b0;
      rd_neg_in    = phase_neg_ff;
      thr_in       = thr_ff;
      tp_in        = tp_ff;
      fn_in        = fn_ff;
      tn_in        = tn_ff;
      fp_in        = fp_ff;
      pos_we       = 1'b0;
      neg_we       = 1'b0;
      pos_re       = 1'b0;
      neg_re       = 1'b0;
      wr_value     = req_score;

      // Negative samples are stored negated, saturating at the most positive value.
      if (req_func == roc_pkg::FuncAddNeg) begin
         if (req_score == roc_pkg::MostNeg) begin
            wr_value = roc_pkg::MostPos;
         end else begin
            wr_value = -req_score;
         end
      end

      // Tally the entry read in the previous cycle.
      if (rd_vld_ff) begin
         if (rd_neg_ff) begin
            if (cmp_ge) begin
               fp_in = fp_ff + 1'b1;
            end else begin
               tn_in = tn_ff + 1'b1;
            end
         end else begin
            if (cmp_ge) begin
               tp_in = tp_ff + 1'b1;
            end else begin
               fn_in = fn_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         roc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  roc_pkg::FuncAddPos: begin
                     if (pos_count_ff >= roc_pkg::CountWidth'(roc_pkg::StoreDepth)) begin
                        overflow_in = 1'b1;
                     end else begin
                        pos_we       = 1'b1;
                        pos_count_in = pos_count_ff + 1'b1;
                        if (wr_value > run_max_ff) run_max_in = wr_value;
                        if (wr_value < run_min_ff) run_min_in = wr_value;
                     end
                  end
                  roc_pkg::FuncAddNeg: begin
                     if (neg_count_ff >= roc_pkg::CountWidth'(roc_pkg::StoreDepth)) begin
                        overflow_in = 1'b1;
                     end else begin
                        neg_we       = 1'b1;
                        neg_count_in = neg_count_ff + 1'b1;
                        if (wr_value > run_max_ff) run_max_in = wr_value;
                        if (wr_value < run_min_ff) run_min_in = wr_value;
                     end
                  end
                  roc_pkg::FuncQuery: begin
                     thr_in       = req_threshold;
                     tp_in        = '0;
                     fn_in        = '0;
                     tn_in        = '0;
                     fp_in        = '0;
                     idx_in       = '0;
                     phase_neg_in = 1'b0;
                     state_in     = roc_pkg::ST_WALK;
                  end
                  default: begin
                     // Unused code: the request is dropped.
                  end
               endcase
            end
         end
         roc_pkg::ST_WALK: begin
            // Issue one read per cycle while entries remain; the compare follows in the next cycle.
            if (!phase_neg_ff) begin
               if (idx_ff < pos_count_ff) begin
                  pos_re    = 1'b1;
                  rd_vld_in = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  phase_neg_in = 1'b1;
                  idx_in       = '0;
               end
            end else begin
               if (idx_ff < neg_count_ff) begin
                  neg_re    = 1'b1;
                  rd_vld_in = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  state_in = roc_pkg::ST_DRAIN;
               end
            end
         end
         roc_pkg::ST_DRAIN: begin
            state_in = roc_pkg::ST_RESULT;
         end
         roc_pkg::ST_RESULT: begin
            state_in = roc_pkg::ST_IDLE;
         end
         default: begin
            state_in = roc_pkg::ST_IDLE;
         end
      endcase
   end

   // Response data ports come straight from registers; busy and rsp_strobe decode the state.
   assign busy          = (state_ff != roc_pkg::ST_IDLE);
   assign rsp_strobe    = (state_ff == roc_pkg::ST_RESULT);
   assign rsp_true_pos  = tp_ff;
   assign rsp_false_neg = fn_ff;
   assign rsp_true_neg  = tn_ff;
   assign rsp_false_pos = fp_ff;
   assign rsp_score_max = run_max_ff;
   assign rsp_score_min = run_min_ff;
   assign rsp_dropped   = overflow_ff;

   // The positive counts of a response cover exactly the stored positive scores.
   a_pos_total : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (roc_pkg::CountWidth'(tp_ff + fn_ff) == pos_count_ff))
      else $error("positive counts do not add up to the store fill");

   // The negative counts of a response cover exactly the stored negative scores.
   a_neg_total : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (roc_pkg::CountWidth'(tn_ff + fp_ff) == neg_count_ff))
      else $error("negative counts do not add up to the store fill");

   // A read in flight was issued by the walk.
   a_read_origin : assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == roc_pkg::ST_WALK))
      else $error("store read outside the walk");

   // The fill counts never pass the store depth.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      (pos_count_ff <= roc_pkg::CountWidth'(roc_pkg::StoreDepth))
      && (neg_count_ff <= roc_pkg::CountWidth'(roc_pkg::StoreDepth)))
      else $error("store fill count beyond depth");

   // No read is pending when the response is shown.
   a_drained : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rd_vld_ff)
      else $error("response shown with a read still pending");

endmodule

// ----- dv/tb_roc_confusion_counter_core.sv -----
// Self-checking testbench for roc_confusion_counter_core: adds scores, queries the
// confusion counts at many thresholds and checks every response against its own predictor.
// Depends on roc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_roc_confusion_counter_core;

   // The one function code that the core takes and ignores.
   localparam logic [1:0] FuncUnused = 2'd3;

   typedef logic signed [roc_pkg::ScoreWidth-1:0] score_type;
   typedef logic [roc_pkg::CountWidth-1:0] count_type;

   // One request waiting to be driven, with its sender behavior.
   typedef struct {
      logic [1:0] func;
      score_type  score;
      score_type  threshold;
      int         idle_pct;
      bit         drain_first;
   } roc_request_type;

   // Counts and extremes that one query returns.
   typedef struct {
      count_type true_pos;
      count_type false_neg;
      count_type true_neg;
      count_type false_pos;
      score_type score_max;
      score_type score_min;
      logic      dropped;
   } confusion_tally_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic [1:0] req_func = roc_pkg::FuncAddPos;
   score_type req_score = '0;
   score_type req_threshold = '0;
   logic      rsp_strobe;
   count_type rsp_true_pos, rsp_false_neg, rsp_true_neg, rsp_false_pos;
   score_type rsp_score_max, rsp_score_min;
   logic      rsp_dropped;

   roc_request_type     pending_requests[$];
   confusion_tally_type expected_tallies[$];

   // Predictor state: the scores as the core stores them, and the running extremes.
   score_type model_pos[$];
   score_type model_neg[$];
   score_type model_max = roc_pkg::MostNeg;
   score_type model_min = roc_pkg::MostPos;
   logic      model_dropped = 1'b0;

   score_type recent_scores[$];
   int        total_requests = 0;
   int        accepted_count = 0;
   int        add_count = 0;
   int        query_count = 0;
   int        drop_reports = 0;
   int        mismatch_count = 0;
   int        gen_pos_adds = 0;

   roc_confusion_counter_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_score     (req_score),
      .req_threshold (req_threshold),
      .rsp_strobe    (rsp_strobe),
      .rsp_true_pos  (rsp_true_pos),
      .rsp_false_neg (rsp_false_neg),
      .rsp_true_neg  (rsp_true_neg),
      .rsp_false_pos (rsp_false_pos),
      .rsp_score_max (rsp_score_max),
      .rsp_score_min (rsp_score_min),
      .rsp_dropped   (rsp_dropped)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Update the predicted stores for one accepted request; queue a tally for a query.
   task automatic predict_confusion(input logic [1:0] func, input score_type score,
                                    input score_type threshold);
      score_type v;
      bit full;
      confusion_tally_type t;
      case (func)
         roc_pkg::FuncAddPos, roc_pkg::FuncAddNeg: begin
            add_count++;
            if (func == roc_pkg::FuncAddPos) begin
               v = score;
               full = model_pos.size() >= roc_pkg::StoreDepth;
            end else begin
               // Negation saturates when the score is the most negative value.
               v = (score == roc_pkg::MostNeg) ? roc_pkg::MostPos : -score;
               full = model_neg.size() >= roc_pkg::StoreDepth;
            end
            if (full) begin
               model_dropped = 1'b1;
            end else begin
               if (v > model_max) model_max = v;
               if (v < model_min) model_min = v;
               if (func == roc_pkg::FuncAddPos) model_pos.insert(model_pos.size(), v);
               else model_neg.insert(model_neg.size(), v);
            end
         end
         roc_pkg::FuncQuery: begin
            t.true_pos = '0;
            t.false_neg = '0;
            t.true_neg = '0;
            t.false_pos = '0;
            foreach (model_pos[i]) begin
               if (model_pos[i] >= threshold) t.true_pos++;
               else t.false_neg++;
            end
            foreach (model_neg[i]) begin
               if (model_neg[i] < threshold) t.true_neg++;
               else t.false_pos++;
            end
            t.score_max = model_max;
            t.score_min = model_min;
            t.dropped = model_dropped;
            expected_tallies.insert(expected_tallies.size(), t);
         end
         default: ;
      endcase
   endtask

   // Driver: takes requests from the pending queue and holds each until it is taken.
   always @(posedge clock) begin
      roc_request_type r;
      if (!reset) begin
         if (start && !busy) begin
            predict_confusion(req_func, req_score, req_threshold);
            accepted_count++;
         end
         if (!(start && busy)) begin
            if (pending_requests.size() != 0 &&
                (!pending_requests[0].drain_first || expected_tallies.size() == 0) &&
                $urandom_range(0, 99) >= pending_requests[0].idle_pct) begin
               r = pending_requests.pop_front();
               req_func <= r.func;
               req_score <= r.score;
               req_threshold <= r.threshold;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name,
                              input logic signed [roc_pkg::ScoreWidth:0] want,
                              input logic signed [roc_pkg::ScoreWidth:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Monitor: every strobed response is matched against the oldest predicted tally.
   always @(posedge clock) begin
      confusion_tally_type t;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_tallies.size() == 0) begin
            mismatch_count++;
            $error("response with no query outstanding");
         end else begin
            t = expected_tallies.pop_front();
            query_count++;
            if (t.dropped) drop_reports++;
            check_field("true_pos", t.true_pos, rsp_true_pos);
            check_field("false_neg", t.false_neg, rsp_false_neg);
            check_field("true_neg", t.true_neg, rsp_true_neg);
            check_field("false_pos", t.false_pos, rsp_false_pos);
            check_field("score_max", t.score_max, rsp_score_max);
            check_field("score_min", t.score_min, rsp_score_min);
            check_field("dropped", t.dropped, rsp_dropped);
         end
      end
   end

   task automatic queue_request(input logic [1:0] func, input score_type score,
                                input score_type threshold, input int idle_pct,
                                input bit drain_first);
      roc_request_type r;
      r.func = func;
      r.score = score;
      r.threshold = threshold;
      r.idle_pct = idle_pct;
      r.drain_first = drain_first;
      pending_requests.insert(pending_requests.size(), r);
      total_requests++;
      if (func == roc_pkg::FuncAddPos) gen_pos_adds++;
      if (func == roc_pkg::FuncAddPos || func == roc_pkg::FuncAddNeg) begin
         recent_scores.insert(recent_scores.size(), score);
         if (recent_scores.size() > 64) void'(recent_scores.pop_front());
      end
   endtask

   // Scores lean toward extremes, small values and whole Q16.16 steps, where ties are likely.
   function automatic score_type pick_score();
      case ($urandom_range(0, 9))
         0: return roc_pkg::MostPos;
         1: return roc_pkg::MostNeg;
         2: return score_type'(int'($urandom_range(0, 8)) - 4);
         3, 4: return score_type'((int'($urandom_range(0, 8)) - 4) <<< 16);
         default: return score_type'($urandom);
      endcase
   endfunction

   // Thresholds often hit a stored score, its negation or a neighbor of it.
   function automatic score_type pick_threshold();
      score_type s;
      if (recent_scores.size() == 0 || $urandom_range(0, 3) == 0) return pick_score();
      s = recent_scores[$urandom_range(0, recent_scores.size() - 1)];
      case ($urandom_range(0, 4))
         0: return s;
         1: return -s;
         2: return s + 1;
         3: return s - 1;
         default: return (s == roc_pkg::MostNeg) ? roc_pkg::MostPos : -s;
      endcase
   endfunction

   // Stimulus, then the end-of-run wait and the verdict.
   initial begin
      int idle_by_phase[4];
      int sel;
      logic [1:0] func;

      idle_by_phase[0] = 0;
      idle_by_phase[1] = 69;
      idle_by_phase[2] = 0;
      idle_by_phase[3] = 21;

      // Directed: empty stores, extreme scores, saturating negation, ties and the unused code.
      queue_request(roc_pkg::FuncQuery, '0, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddPos, roc_pkg::MostPos, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddPos, roc_pkg::MostNeg, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddPos, '0, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddPos, -1, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddNeg, roc_pkg::MostNeg, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddNeg, roc_pkg::MostPos, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddNeg, '0, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddNeg, 1, '0, 0, 1'b0);
      queue_request(FuncUnused, score_type'($urandom), score_type'($urandom), 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, '0, roc_pkg::MostNeg, 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, '0, roc_pkg::MostPos, 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, '0, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, '0, -1, 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, '0, 1, 0, 1'b0);
      queue_request(roc_pkg::FuncAddPos, 32'h0001_0000, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncAddNeg, 32'hFFFF_0000, '0, 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, score_type'($urandom), 32'h0001_0000, 0, 1'b0);
      queue_request(FuncUnused, score_type'($urandom), score_type'($urandom), 0, 1'b0);
      queue_request(roc_pkg::FuncQuery, score_type'($urandom), roc_pkg::MostPos - 1, 0, 1'b0);

      // Random phases; each opens only once every earlier response has come back.
      // The last phase leans on positive adds so that the positive store overflows.
      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < 488; n++) begin
            sel = $urandom_range(0, 99);
            if (phase == 3 && gen_pos_adds < 1060) sel = sel / 2;
            if (sel < 56) func = roc_pkg::FuncAddPos;
            else if (sel < 90) func = roc_pkg::FuncAddNeg;
            else if (sel < 97) func = roc_pkg::FuncQuery;
            else func = FuncUnused;
            queue_request(func, pick_score(), pick_threshold(), idle_by_phase[phase], n == 0);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || expected_tallies.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d requests: %0d adds, %0d queries checked, %0d after a dropped add.",
               accepted_count, add_count, query_count, drop_reports);
      $display("Final store fill: %0d positive, %0d negative.", model_pos.size(),
               model_neg.size());
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #100_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/roc_pkg.sv
rtl/roc_confusion_counter_core.sv
dv/tb_roc_confusion_counter_core.sv
